// ===== sv/rpt_pkg.sv =====
// Package with the shared widths, codes and pipeline item type of the polynomial tone map.
`default_nettype none
package rpt_pkg;

    localparam int FRAC_W         = 24;
    localparam int SAMPLE_W       = 16;
    localparam int INV_W          = 32;
    localparam int X_W            = SAMPLE_W + FRAC_W;
    localparam int ACC_W          = 48;
    localparam int COEF_W         = 32;
    localparam int NUM_LANES      = 3;
    localparam int DEG_W          = 4;
    localparam int CH_W           = 2;
    localparam int IDX_W          = 4;
    localparam int RANGE_W        = 16;
    localparam int MAG_LO_W       = ACC_W / 2;
    localparam int X_LO_W         = X_W / 2;
    localparam int PP_W           = (ACC_W - MAG_LO_W) + (X_W - X_LO_W);
    localparam int PROD_W         = ACC_W + X_W;
    localparam int MAX_DEGREE_DEF = 8;
    localparam int CHANNELS_DEF   = 3;

    typedef enum logic [2:0]
    {
        REG_PIXEL_RANGE   = 3'd0,
        REG_INVERSE_RANGE = 3'd1,
        REG_DEGREE_RED    = 3'd2,
        REG_DEGREE_GREEN  = 3'd3,
        REG_DEGREE_BLUE   = 3'd4
    } reg_index_t;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_LOAD  = 1'b1
    } opcode_t;

    typedef logic [NUM_LANES-1:0][DEG_W-1:0] deg_vec_t;

    typedef struct packed
    {
        logic                               load;
        logic [CH_W-1:0]                    ch;
        logic [IDX_W-1:0]                   idx;
        logic [COEF_W-1:0]                  value;
        logic [NUM_LANES-1:0][X_W-1:0]      x;
        logic [NUM_LANES-1:0][ACC_W-1:0]    acc;
    } item_t;

endpackage
`default_nettype wire

// ===== sv/rpt_horner_step.sv =====
// One Horner step of the tone map: split multiply stage, then sum, saturate and add stage.
`default_nettype none
module rpt_horner_step #(
    parameter int POWER    = 0,
    parameter int CHANNELS = rpt_pkg::CHANNELS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rpt_pkg::deg_vec_t degree,
    input  wire logic              in_valid,
    input  wire rpt_pkg::item_t    in_item,
    output logic                   in_ready,
    output logic                   out_valid,
    output rpt_pkg::item_t         out_item,
    input  wire logic              out_ready
);

    localparam int NL = rpt_pkg::NUM_LANES;
    localparam int AW = rpt_pkg::ACC_W;
    localparam int PW = rpt_pkg::PP_W;
    localparam int QW = rpt_pkg::PROD_W;
    localparam int FW = rpt_pkg::FRAC_W;
    localparam int ML = rpt_pkg::MAG_LO_W;
    localparam int XL = rpt_pkg::X_LO_W;
    localparam int CW = rpt_pkg::COEF_W;

    logic                        a_valid_reg;
    rpt_pkg::item_t              a_item_reg;
    logic [NL-1:0][PW-1:0]       pp_ll_reg;
    logic [NL-1:0][PW-1:0]       pp_lh_reg;
    logic [NL-1:0][PW-1:0]       pp_hl_reg;
    logic [NL-1:0][PW-1:0]       pp_hh_reg;
    logic [NL-1:0]               neg_reg;
    logic                        b_valid_reg;
    rpt_pkg::item_t              b_item_reg;
    logic [NL-1:0][CW-1:0]       bank_reg;

    logic                        ready_a;
    logic                        ready_b;
    logic [NL-1:0][AW-1:0]       mag;
    logic [NL-1:0]               neg_next;
    logic [NL-1:0][PW-1:0]       pp_ll_next;
    logic [NL-1:0][PW-1:0]       pp_lh_next;
    logic [NL-1:0][PW-1:0]       pp_hl_next;
    logic [NL-1:0][PW-1:0]       pp_hh_next;
    logic [NL-1:0][QW-1:0]       prod;
    logic [NL-1:0][AW-1:0]       pcap;
    logic [NL-1:0][AW+1:0]       sp;
    logic [NL-1:0][AW+1:0]       coef_x;
    logic [NL-1:0][AW+1:0]       total;
    rpt_pkg::item_t              b_item_next;
    logic [NL-1:0]               bank_we;

    assign ready_b   = !b_valid_reg || out_ready;
    assign ready_a   = !a_valid_reg || ready_b;
    assign in_ready  = ready_a;
    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

    always_comb
    begin
        for (int c = 0; c < NL; c++)
        begin
            neg_next[c]   = in_item.acc[c][AW-1];
            mag[c]        = neg_next[c] ? (AW'(0) - in_item.acc[c]) : in_item.acc[c];
            pp_ll_next[c] = PW'(mag[c][ML-1:0]) * PW'(in_item.x[c][XL-1:0]);
            pp_lh_next[c] = PW'(mag[c][ML-1:0]) * PW'(in_item.x[c][rpt_pkg::X_W-1:XL]);
            pp_hl_next[c] = PW'(mag[c][AW-1:ML]) * PW'(in_item.x[c][XL-1:0]);
            pp_hh_next[c] = PW'(mag[c][AW-1:ML]) * PW'(in_item.x[c][rpt_pkg::X_W-1:XL]);
        end
    end

    always_comb
    begin
        b_item_next = a_item_reg;
        for (int c = 0; c < NL; c++)
        begin
            prod[c] = QW'(pp_ll_reg[c]) + (QW'(pp_lh_reg[c]) << XL)
                    + (QW'(pp_hl_reg[c]) << ML) + (QW'(pp_hh_reg[c]) << (ML + XL));
            if (|prod[c][QW-1:FW+AW-1])
            begin
                pcap[c] = {1'b1, {(AW-1){1'b0}}};
            end
            else
            begin
                pcap[c] = {1'b0, prod[c][FW+AW-2:FW]};
            end
            sp[c] = neg_reg[c] ? ((AW+2)'(0) - {2'b00, pcap[c]}) : {2'b00, pcap[c]};
            if (32'(degree[c]) >= POWER)
            begin
                coef_x[c] = {{(AW+2-CW){bank_reg[c][CW-1]}}, bank_reg[c]};
            end
            else
            begin
                coef_x[c] = '0;
            end
            total[c] = coef_x[c] + sp[c];
            if (total[c][AW+1:AW-1] == 3'b000 || total[c][AW+1:AW-1] == 3'b111)
            begin
                b_item_next.acc[c] = total[c][AW-1:0];
            end
            else if (!total[c][AW+1])
            begin
                b_item_next.acc[c] = {1'b0, {(AW-1){1'b1}}};
            end
            else
            begin
                b_item_next.acc[c] = {1'b1, {(AW-1){1'b0}}};
            end
            bank_we[c] = a_valid_reg && ready_b && a_item_reg.load
                       && (32'(a_item_reg.idx) == POWER)
                       && (32'(a_item_reg.ch) == c) && (c < CHANNELS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            bank_reg    <= '0;
        end
        else
        begin
            if (ready_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (ready_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            for (int c = 0; c < NL; c++)
            begin
                if (bank_we[c])
                begin
                    bank_reg[c] <= a_item_reg.value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a)
        begin
            a_item_reg <= in_item;
            pp_ll_reg  <= pp_ll_next;
            pp_lh_reg  <= pp_lh_next;
            pp_hl_reg  <= pp_hl_next;
            pp_hh_reg  <= pp_hh_next;
            neg_reg    <= neg_next;
        end
        if (ready_b)
        begin
            b_item_reg <= b_item_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/rgb_polynomial_tone_map_top.sv =====
// Top level of the RGB polynomial tone map: config port, normalize, Horner chain and output scale.
// The block maps each RGB pixel through a per-channel polynomial evaluated by Horner's rule.
// Requests arrive on the s_ channel; s_tuser selects a pixel request or a coefficient load.
// A coefficient load updates at most one table entry in request order and produces no result.
// Each pixel request yields one result on the m_ channel with the three mapped samples.
// The user must write registers over the APB port only while no request is in flight; unchecked.
// A request passes an input register, a normalize stage, two stages for each Horner power,
// and the output register. Throughput is one request per cycle while m_tready is held high;
// each Horner power has its own multiply and add stages.
// Every stage moves forward when the stage after it is empty or moving, so bubbles close up
// and requests keep being accepted while a result waits, until every stage is full.
// When the receiver holds m_tready low, the result stays on m_tdata and nothing is lost.
// Reset empties the pipeline, clears the coefficient table and loads the register reset values.
`default_nettype none
module rgb_polynomial_tone_map_top #(
    parameter int MAX_DEGREE = rpt_pkg::MAX_DEGREE_DEF,
    parameter int CHANNELS   = rpt_pkg::CHANNELS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // red_in[15:0], green_in[31:16], blue_in[47:32], coeff_channel[49:48],
    // coeff_index[53:50], coeff_value[85:54], zero fill[87:86].
    input  wire logic [87:0] s_tdata,
    // opcode[0].
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // red_out[15:0], green_out[31:16], blue_out[47:32].
    output logic [47:0]      m_tdata
);

    localparam int NL = rpt_pkg::NUM_LANES;
    localparam int SW = rpt_pkg::SAMPLE_W;
    localparam int IW = rpt_pkg::INV_W;
    localparam int AW = rpt_pkg::ACC_W;
    localparam int FW = rpt_pkg::FRAC_W;
    localparam int CW = rpt_pkg::COEF_W;
    localparam int RW = rpt_pkg::RANGE_W;
    localparam int YW = FW + 1;

    logic [RW-1:0]                  pixel_range_reg;
    logic [IW-1:0]                  inverse_range_reg;
    logic [rpt_pkg::DEG_W-1:0]      degree_red_reg;
    logic [rpt_pkg::DEG_W-1:0]      degree_green_reg;
    logic [rpt_pkg::DEG_W-1:0]      degree_blue_reg;
    rpt_pkg::deg_vec_t              degree;
    rpt_pkg::reg_index_t            reg_sel;
    logic                           cfg_write;

    logic                           s0_valid_reg;
    logic                           s0_load_reg;
    logic [NL-1:0][SW-1:0]          s0_sample_reg;
    logic [rpt_pkg::CH_W-1:0]       s0_ch_reg;
    logic [rpt_pkg::IDX_W-1:0]      s0_idx_reg;
    logic [CW-1:0]                  s0_value_reg;
    logic                           s0_ready;

    logic [NL-1:0][CW-1:0]          bank_top_reg;
    logic [NL-1:0]                  bank_top_we;
    logic [NL-1:0][SW+IW-1:0]       norm_prod;
    rpt_pkg::item_t                 s1_item_next;
    logic                           s1_valid_reg;
    rpt_pkg::item_t                 s1_item_reg;

    logic [MAX_DEGREE:0]            chain_valid;
    rpt_pkg::item_t                 chain_item [MAX_DEGREE+1];
    logic [MAX_DEGREE:0]            chain_ready;

    logic                           out_ready;
    logic [NL-1:0][YW-1:0]          y;
    logic [NL-1:0][YW+RW-1:0]       scaled;
    logic [NL-1:0][SW-1:0]          result_next;
    logic [NL-1:0][SW-1:0]          result_reg;
    logic                           m_tvalid_reg;

    assign degree    = {degree_blue_reg, degree_green_reg, degree_red_reg};
    assign reg_sel   = rpt_pkg::reg_index_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        case (reg_sel)
            rpt_pkg::REG_PIXEL_RANGE:   prdata = 32'(pixel_range_reg);
            rpt_pkg::REG_INVERSE_RANGE: prdata = inverse_range_reg;
            rpt_pkg::REG_DEGREE_RED:    prdata = 32'(degree_red_reg);
            rpt_pkg::REG_DEGREE_GREEN:  prdata = 32'(degree_green_reg);
            rpt_pkg::REG_DEGREE_BLUE:   prdata = 32'(degree_blue_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_range_reg   <= 16'hFFFF;
            inverse_range_reg <= 32'h0001_0001;
            degree_red_reg    <= '0;
            degree_green_reg  <= '0;
            degree_blue_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                rpt_pkg::REG_PIXEL_RANGE:   pixel_range_reg   <= pwdata[RW-1:0];
                rpt_pkg::REG_INVERSE_RANGE: inverse_range_reg <= pwdata[IW-1:0];
                rpt_pkg::REG_DEGREE_RED:    degree_red_reg    <= pwdata[rpt_pkg::DEG_W-1:0];
                rpt_pkg::REG_DEGREE_GREEN:  degree_green_reg  <= pwdata[rpt_pkg::DEG_W-1:0];
                rpt_pkg::REG_DEGREE_BLUE:   degree_blue_reg   <= pwdata[rpt_pkg::DEG_W-1:0];
                default:                    ;
            endcase
        end
    end

    assign s0_ready = !s0_valid_reg || chain_ready[0];
    assign s_tready = s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready)
        begin
            s0_load_reg      <= (rpt_pkg::opcode_t'(s_tuser) == rpt_pkg::OP_LOAD);
            s0_sample_reg[0] <= s_tdata[15:0];
            s0_sample_reg[1] <= s_tdata[31:16];
            s0_sample_reg[2] <= s_tdata[47:32];
            s0_ch_reg        <= s_tdata[49:48];
            s0_idx_reg       <= s_tdata[53:50];
            s0_value_reg     <= s_tdata[85:54];
        end
    end

    always_comb
    begin
        s1_item_next.load  = s0_load_reg;
        s1_item_next.ch    = s0_ch_reg;
        s1_item_next.idx   = s0_idx_reg;
        s1_item_next.value = s0_value_reg;
        for (int c = 0; c < NL; c++)
        begin
            norm_prod[c]       = (SW+IW)'(s0_sample_reg[c]) * (SW+IW)'(inverse_range_reg);
            s1_item_next.x[c]  = norm_prod[c][SW+IW-1:IW-FW];
            if (32'(degree[c]) >= MAX_DEGREE)
            begin
                s1_item_next.acc[c] = {{(AW-CW){bank_top_reg[c][CW-1]}}, bank_top_reg[c]};
            end
            else
            begin
                s1_item_next.acc[c] = '0;
            end
            bank_top_we[c] = s0_valid_reg && chain_ready[0] && s0_load_reg
                           && (32'(s0_idx_reg) == MAX_DEGREE)
                           && (32'(s0_ch_reg) == c) && (c < CHANNELS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_top_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < NL; c++)
            begin
                if (bank_top_we[c])
                begin
                    bank_top_reg[c] <= s0_value_reg;
                end
            end
            if (chain_ready[0])
            begin
                s1_valid_reg <= s0_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_ready[0])
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    assign chain_valid[0] = s1_valid_reg;
    assign chain_item[0]  = s1_item_reg;

    for (genvar j = 0; j < MAX_DEGREE; j++)
    begin : g_step
        logic step_in_ready;

        assign chain_ready[j] = !chain_valid[0 + j] || step_in_ready;

        rpt_horner_step #(
            .POWER    (MAX_DEGREE - 1 - j),
            .CHANNELS (CHANNELS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .degree    (degree),
            .in_valid  (chain_valid[j]),
            .in_item   (chain_item[j]),
            .in_ready  (step_in_ready),
            .out_valid (chain_valid[j+1]),
            .out_item  (chain_item[j+1]),
            .out_ready (chain_ready[j+1])
        );
    end

    assign out_ready               = !m_tvalid_reg || m_tready;
    assign chain_ready[MAX_DEGREE] = out_ready;

    always_comb
    begin
        for (int c = 0; c < NL; c++)
        begin
            if (chain_item[MAX_DEGREE].acc[c][AW-1])
            begin
                y[c] = '0;
            end
            else if (|chain_item[MAX_DEGREE].acc[c][AW-2:FW+1]
                     || (chain_item[MAX_DEGREE].acc[c][FW]
                         && |chain_item[MAX_DEGREE].acc[c][FW-1:0]))
            begin
                y[c] = {1'b1, {FW{1'b0}}};
            end
            else
            begin
                y[c] = chain_item[MAX_DEGREE].acc[c][FW:0];
            end
            scaled[c] = (YW+RW)'(y[c]) * (YW+RW)'(pixel_range_reg)
                      + ((YW+RW)'(1) << (FW - 1));
            result_next[c] = (c < CHANNELS) ? scaled[c][FW+SW-1:FW] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            m_tvalid_reg <= chain_valid[MAX_DEGREE] && !chain_item[MAX_DEGREE].load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {result_reg[2], result_reg[1], result_reg[0]};

    a_stall_only_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("Input stalled while the output register was free.");

    a_stall_needs_full_input: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s0_valid_reg)
        else $error("Input stalled while the input register was empty.");

    a_load_gives_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid && chain_valid[MAX_DEGREE] && chain_item[MAX_DEGREE].load) |=> !m_tvalid)
        else $error("A coefficient load produced a result.");

endmodule
`default_nettype wire

// ===== verif/rgb_polynomial_tone_map_top_tb.sv =====
// Self-checking testbench for the RGB polynomial tone map: APB setup, streamed requests, checked results.
`timescale 1ns / 100ps
module rgb_polynomial_tone_map_top_tb;

    localparam int NCOEF = rpt_pkg::MAX_DEGREE_DEF + 1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        rpt_pkg::opcode_t op;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [1:0]  ch;
        logic [3:0]  idx;
        logic [31:0] value;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    request_t    pending_requests[$];
    logic [47:0] expected_pixels[$];
    logic [31:0] coef_table[3][NCOEF];
    logic [15:0] range_reg;
    logic [31:0] inv_reg;
    logic [3:0]  deg_reg[3];
    int          failures;
    int          cycles;
    bit          in_taken;
    int          hold_off;
    bit          driving;
    bit          long_hold;

    rgb_polynomial_tone_map_top i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [63:0] coef_signed(int ch, int k);
        return {{32{coef_table[ch][k][31]}}, coef_table[ch][k]};
    endfunction

    function automatic logic [15:0] tone_map_sample(int ch, logic [15:0] sample);
        logic [127:0]       full;
        logic [63:0]        x;
        logic [63:0]        mag;
        logic [63:0]        prod;
        logic signed [63:0] acc;
        logic signed [63:0] signed_prod;
        logic [63:0]        y;
        int                 deg;
        deg = deg_reg[ch] > rpt_pkg::MAX_DEGREE_DEF ? rpt_pkg::MAX_DEGREE_DEF : deg_reg[ch];
        x = (64'(sample) * 64'(inv_reg)) >> (32 - rpt_pkg::FRAC_W);
        acc = coef_signed(ch, deg);
        for (int k = deg; k > 0; k--)
        begin
            mag = acc < 0 ? 64'(-acc) : 64'(acc);
            full = 128'(mag) * 128'(x);
            full = full >> rpt_pkg::FRAC_W;
            prod = full > (128'd1 << 47) ? (64'd1 << 47) : full[63:0];
            signed_prod = acc < 0 ? -$signed(prod) : $signed(prod);
            acc = coef_signed(ch, k - 1) + signed_prod;
            if (acc > 64'sh7FFF_FFFF_FFFF)
                acc = 64'sh7FFF_FFFF_FFFF;
            else if (acc < -64'sh8000_0000_0000)
                acc = -64'sh8000_0000_0000;
        end
        if (acc < 0)
            y = 0;
        else if (acc > (64'sd1 <<< rpt_pkg::FRAC_W))
            y = 64'd1 << rpt_pkg::FRAC_W;
        else
            y = acc;
        y = (y * 64'(range_reg) + (64'd1 << (rpt_pkg::FRAC_W - 1))) >> rpt_pkg::FRAC_W;
        return y[15:0];
    endfunction

    task automatic apply_request(request_t r);
        if (r.op == rpt_pkg::OP_LOAD)
        begin
            if (r.ch < 3 && r.idx <= rpt_pkg::MAX_DEGREE_DEF)
                coef_table[r.ch][r.idx] = r.value;
        end
        else
            expected_pixels.push_back({tone_map_sample(2, r.blue), tone_map_sample(1, r.green),
                                       tone_map_sample(0, r.red)});
    endtask

    task automatic write_register(rpt_pkg::reg_index_t index, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 5'(index) << 2;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (index)
            rpt_pkg::REG_PIXEL_RANGE:   range_reg = value[15:0];
            rpt_pkg::REG_INVERSE_RANGE: inv_reg = value;
            rpt_pkg::REG_DEGREE_RED:    deg_reg[0] = value[3:0];
            rpt_pkg::REG_DEGREE_GREEN:  deg_reg[1] = value[3:0];
            default:                    deg_reg[2] = value[3:0];
        endcase
    endtask

    function automatic request_t random_pixel();
        request_t r;
        r.op = rpt_pkg::OP_PIXEL;
        r.red = 16'($urandom);
        r.green = 16'($urandom);
        r.blue = 16'($urandom);
        r.ch = 2'($urandom);
        r.idx = 4'($urandom);
        r.value = $urandom;
        if ($urandom_range(0, 4) == 0)
        begin
            r.red = range_reg;
            r.green = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
        end
        return r;
    endfunction

    function automatic request_t random_load();
        request_t r;
        r = random_pixel();
        r.op = rpt_pkg::OP_LOAD;
        r.ch = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
        r.idx = $urandom_range(0, 9) == 0 ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        case ($urandom_range(0, 3))
            0: r.value = $urandom;
            1: r.value = $urandom_range(0, 32'h0100_0000);
            2: r.value = -$urandom_range(0, 32'h0080_0000);
            default: r.value = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
        return r;
    endfunction

    task automatic run_phase(int count);
        for (int i = 0; i < count; i++)
            pending_requests.push_back($urandom_range(0, 4) == 0 ? random_load() : random_pixel());
        wait (pending_requests.size() == 0 && !driving);
        wait (expected_pixels.size() == 0);
        repeat (25) @(posedge clk);
    endtask

    initial
    begin
        request_t r;
        int       sample_range;
        failures = 0;
        cycles = 0;
        in_taken = 1'b0;
        hold_off = 0;
        driving = 1'b0;
        long_hold = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        range_reg = 16'hFFFF;
        inv_reg = 32'd65537;
        for (int c = 0; c < 3; c++)
        begin
            deg_reg[c] = '0;
            for (int k = 0; k < NCOEF; k++)
                coef_table[c][k] = '0;
        end
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(posedge clk);

        r = random_pixel();
        r.red = 16'h0;
        r.green = 16'hFFFF;
        r.blue = 16'h8000;
        pending_requests.push_back(r);
        run_phase(0);
        write_register(rpt_pkg::REG_DEGREE_RED, 4'd8);
        write_register(rpt_pkg::REG_DEGREE_GREEN, 4'd15);
        write_register(rpt_pkg::REG_DEGREE_BLUE, 4'd1);
        for (int k = 0; k <= 8; k++)
        begin
            r = random_load();
            r.ch = 2'(k % 3);
            r.idx = 4'(k);
            r.value = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            pending_requests.push_back(r);
        end
        r.ch = 2'd3;
        pending_requests.push_back(r);
        r.ch = 2'd0;
        r.idx = 4'd15;
        pending_requests.push_back(r);
        r.idx = 4'd0;
        r.value = 32'h0100_0000;
        pending_requests.push_back(r);
        for (int i = 0; i < 6; i++)
        begin
            r = random_pixel();
            r.red = i[0] ? 16'hFFFF : 16'h0;
            r.blue = 16'hFFFF;
            pending_requests.push_back(r);
        end
        run_phase(0);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: sample_range = 65535;
                1: sample_range = 1;
                2: sample_range = 0;
                default: sample_range = $urandom_range(1, 65535);
            endcase
            write_register(rpt_pkg::REG_PIXEL_RANGE, 32'(sample_range));
            case (phase)
                0: write_register(rpt_pkg::REG_INVERSE_RANGE, 32'hFFFF_FFFF);
                1: write_register(rpt_pkg::REG_INVERSE_RANGE, 32'h0);
                default: write_register(rpt_pkg::REG_INVERSE_RANGE,
                    sample_range == 0 ? 32'h1 : 32'(64'h1_0000_0000 / sample_range));
            endcase
            write_register(rpt_pkg::REG_DEGREE_RED,
                           phase == 0 ? 4'd0 : 4'($urandom_range(0, 15)));
            write_register(rpt_pkg::REG_DEGREE_GREEN,
                           phase == 0 ? 4'd8 : 4'($urandom_range(0, 8)));
            write_register(rpt_pkg::REG_DEGREE_BLUE, 4'($urandom_range(0, 8)));
            if (phase == 3)
                long_hold = 1'b1;
            run_phase(135);
        end
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !in_taken)
            begin
            end
            else if (pending_requests.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                request_t r;
                r = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= r.op;
                s_tdata <= {2'b00, r.value, r.idx, r.ch, r.blue, r.green, r.red};
                apply_request(r);
                driving <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
                driving <= 1'b0;
                if ($urandom_range(0, 15) == 0)
                    repeat ($urandom_range(5, 30)) @(negedge clk);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                hold_off <= hold_off + 1;
                if (hold_off == 200)
                    long_hold <= 1'b0;
            end
            else if ($urandom_range(0, 31) == 0)
                m_tready <= 1'b0;
            else if ($urandom_range(0, 3) != 0 || m_tready)
                m_tready <= $urandom_range(0, 4) != 0;
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        in_taken <= s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result %h", m_tdata);
                failures = failures + 1;
            end
            else
            begin
                logic [47:0] want;
                want = expected_pixels.pop_front();
                if (want[15:0] !== m_tdata[15:0])
                begin
                    $error("red_out expected %h actual %h", want[15:0], m_tdata[15:0]);
                    failures = failures + 1;
                end
                if (want[31:16] !== m_tdata[31:16])
                begin
                    $error("green_out expected %h actual %h", want[31:16], m_tdata[31:16]);
                    failures = failures + 1;
                end
                if (want[47:32] !== m_tdata[47:32])
                begin
                    $error("blue_out expected %h actual %h", want[47:32], m_tdata[47:32]);
                    failures = failures + 1;
                end
            end
        end
    end
endmodule
